// File: hw/rtl/coin_transaction_stream_parser_core_assert.svh
// ============================================================================
// Assertion macros for the transaction stream parser
// Shared concurrent assertion forms, all qualified by clock and
// active-low synchronous reset.
// ============================================================================
`ifndef COIN_TRANSACTION_STREAM_PARSER_CORE_ASSERT_SVH
`define COIN_TRANSACTION_STREAM_PARSER_CORE_ASSERT_SVH

// Same-cycle implication: when ante holds, cons must hold.
`define CTSP_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication: when ante holds, cons must hold in the next cycle.
`define CTSP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hw/rtl/ctsp_pkg.sv
// ============================================================================
// Transaction stream parser package
// Parse phase codes, which double as result field kinds, and the
// compact-size prefix values.
// ============================================================================
`default_nettype none

package ctsp_pkg;

    // Parse phases; a result carries the code of the phase that produced it.
    localparam logic [3:0] PH_VERSION = 4'd0;
    localparam logic [3:0] PH_INCNT   = 4'd1;
    localparam logic [3:0] PH_HASH    = 4'd2;
    localparam logic [3:0] PH_PIDX    = 4'd3;
    localparam logic [3:0] PH_SIGLEN  = 4'd4;
    localparam logic [3:0] PH_SIG     = 4'd5;
    localparam logic [3:0] PH_SEQ     = 4'd6;
    localparam logic [3:0] PH_OUTCNT  = 4'd7;
    localparam logic [3:0] PH_AMT     = 4'd8;
    localparam logic [3:0] PH_PKLEN   = 4'd9;
    localparam logic [3:0] PH_PK      = 4'd10;
    localparam logic [3:0] PH_LOCK    = 4'd11;

    // Compact-size prefixes that announce 2, 4 or 8 count bytes.
    localparam logic [7:0] PFX_U16 = 8'hFD;
    localparam logic [7:0] PFX_U32 = 8'hFE;
    localparam logic [7:0] PFX_U64 = 8'hFF;

    // Fixed field lengths in bytes.
    localparam logic [7:0] LEN_WORD = 8'd4;
    localparam logic [7:0] LEN_AMT  = 8'd8;
    localparam logic [7:0] LEN_HASH = 8'd32;

endpackage

`default_nettype wire

// File: hw/rtl/coin_transaction_stream_parser_core.sv
// ============================================================================
// Transaction stream parser core
// Decodes a serialized coin transaction, one byte per transfer, into a
// stream of field results.
// ============================================================================
// The block takes one transaction byte per clock cycle while the result stream
// is not stalled by m_axis_tready. Each byte is held in the input register and
// its result in the result register. Every byte is decoded by a single
// pass of logic between those two registers, which is what sets the rate.
// A result is a completed multi-byte field (version, counts, previous index,
// sequence, amount, lock time), a length byte, or one hash or script byte.
// m_axis_tlast marks the lock time that ends a transaction; the next byte
// starts a new one. A count that does not fit in COUNT_BITS bits is reported
// with the error flag in m_axis_tuser, and the parser restarts at the version.
`default_nettype none

`include "coin_transaction_stream_parser_core_assert.svh"

module coin_transaction_stream_parser_core #(
    parameter int COUNT_BITS = 32
) (
    input  wire          i_clk,
    input  wire          i_rst_n,
    // Input stream. tdata: data_byte [7:0].
    input  wire          s_axis_tvalid,
    output logic         s_axis_tready,
    input  wire  [7:0]   s_axis_tdata,
    // Result stream. tdata: field_value [63:0], entry_index [95:64],
    // byte_position [103:96].
    output logic         m_axis_tvalid,
    input  wire          m_axis_tready,
    output logic [103:0] m_axis_tdata,
    // tuser: field_kind [3:0], count_error [4].
    output logic [4:0]   m_axis_tuser,
    // tlast: tx_end.
    output logic         m_axis_tlast
);
    import ctsp_pkg::*;

    // Bits from COUNT_BITS upward that make a count oversized.
    localparam logic [63:0] LP_OVER_MASK =
        (COUNT_BITS >= 64) ? 64'd0 : ~((64'd1 << COUNT_BITS) - 64'd1);

    // Input register.
    logic        r_in_valid;
    logic [7:0]  r_in_byte;

    // Parser state.
    logic [3:0]            r_phase,   n_phase;
    logic [7:0]            r_fbc,     n_fbc;
    logic [63:0]           r_acc,     n_acc;
    logic [3:0]            r_vlen,    n_vlen;
    logic [COUNT_BITS-1:0] r_ecount,  n_ecount;
    logic [COUNT_BITS-1:0] r_etotal,  n_etotal;
    logic [7:0]            r_srem,    n_srem;

    // Result register.
    logic        r_out_valid;
    logic [3:0]  r_out_kind;
    logic [63:0] r_out_value;
    logic [31:0] r_out_index;
    logic [7:0]  r_out_pos;
    logic        r_out_end;
    logic        r_out_err;

    // Decode results.
    logic        w_res_valid;
    logic [3:0]  w_res_kind;
    logic [63:0] w_res_value;
    logic [31:0] w_res_index;
    logic [7:0]  w_res_pos;
    logic        w_res_end;
    logic        w_res_err;

    logic              w_out_free;
    logic              w_advance;
    logic [63:0]       w_merged;
    logic [7:0]        w_fbc_inc;
    logic [63:0]       w_cnt_wide;
    logic [31:0]       w_index;
    logic [COUNT_BITS:0] w_cnt_next;
    logic              w_last_entry;
    logic              w_cnt_done;
    logic [63:0]       w_cnt_val;

    // Handshake: the input stage moves whenever the result register can take.
    assign w_out_free    = !r_out_valid || m_axis_tready;
    assign w_advance     = r_in_valid && w_out_free;
    assign s_axis_tready = !r_in_valid || w_out_free;

    // Shared datapath pieces.
    assign w_merged     = r_acc | ({56'd0, r_in_byte} << {r_fbc[2:0], 3'b000});
    assign w_fbc_inc    = r_fbc + 8'd1;
    assign w_cnt_wide   = 64'(r_ecount);
    assign w_index      = w_cnt_wide[31:0];
    assign w_cnt_next   = {1'b0, r_ecount} + {{COUNT_BITS{1'b0}}, 1'b1};
    assign w_last_entry = (w_cnt_next >= {1'b0, r_etotal});

    // Byte decode: next state and the optional result for the held byte.
    always_comb begin
        n_phase  = r_phase;
        n_fbc    = r_fbc;
        n_acc    = r_acc;
        n_vlen   = r_vlen;
        n_ecount = r_ecount;
        n_etotal = r_etotal;
        n_srem   = r_srem;

        w_res_valid = 1'b0;
        w_res_kind  = r_phase;
        w_res_value = {56'd0, r_in_byte};
        w_res_index = w_index;
        w_res_pos   = 8'd0;
        w_res_end   = 1'b0;
        w_res_err   = 1'b0;

        w_cnt_done = 1'b0;
        w_cnt_val  = 64'd0;

        case (r_phase)
            PH_VERSION, PH_PIDX, PH_SEQ, PH_AMT, PH_LOCK: begin
                // Fixed little-endian fields.
                n_acc = w_merged;
                n_fbc = w_fbc_inc;
                if (w_fbc_inc >= ((r_phase == PH_AMT) ? LEN_AMT : LEN_WORD)) begin
                    w_res_valid = 1'b1;
                    w_res_value = w_merged;
                    n_acc       = 64'd0;
                    n_fbc       = 8'd0;
                    if (r_phase == PH_VERSION) begin
                        w_res_index = 32'd0;
                        n_phase     = PH_INCNT;
                    end else if (r_phase == PH_PIDX) begin
                        n_phase = PH_SIGLEN;
                    end else if (r_phase == PH_AMT) begin
                        n_phase = PH_PKLEN;
                    end else if (r_phase == PH_SEQ) begin
                        n_ecount = w_last_entry ? '0 : w_cnt_next[COUNT_BITS-1:0];
                        n_phase  = w_last_entry ? PH_OUTCNT : PH_HASH;
                    end else begin
                        // Lock time ends the transaction.
                        w_res_index = 32'd0;
                        w_res_end   = 1'b1;
                        n_phase     = PH_VERSION;
                        n_vlen      = 4'd0;
                        n_ecount    = '0;
                        n_etotal    = '0;
                        n_srem      = 8'd0;
                    end
                end
            end
            PH_INCNT, PH_OUTCNT: begin
                // Compact-size count: prefix byte, then optional value bytes.
                if (r_vlen == 4'd0) begin
                    if (r_in_byte < PFX_U16) begin
                        w_cnt_done = 1'b1;
                        w_cnt_val  = {56'd0, r_in_byte};
                    end else begin
                        n_vlen = (r_in_byte == PFX_U16) ? 4'd2 :
                                 (r_in_byte == PFX_U32) ? 4'd4 : 4'd8;
                        n_fbc  = 8'd0;
                        n_acc  = 64'd0;
                    end
                end else begin
                    n_acc = w_merged;
                    n_fbc = w_fbc_inc;
                    if (w_fbc_inc >= {4'd0, r_vlen}) begin
                        w_cnt_done = 1'b1;
                        w_cnt_val  = w_merged;
                    end
                end
                if (w_cnt_done) begin
                    w_res_valid = 1'b1;
                    w_res_value = w_cnt_val;
                    w_res_index = 32'd0;
                    n_vlen      = 4'd0;
                    n_fbc       = 8'd0;
                    n_acc       = 64'd0;
                    if ((w_cnt_val & LP_OVER_MASK) != 64'd0) begin
                        // Oversized count: flag it and restart.
                        w_res_err = 1'b1;
                        n_phase   = PH_VERSION;
                        n_ecount  = '0;
                        n_etotal  = '0;
                        n_srem    = 8'd0;
                    end else begin
                        n_etotal = w_cnt_val[COUNT_BITS-1:0];
                        n_ecount = '0;
                        if (r_phase == PH_INCNT) begin
                            n_phase = (w_cnt_val == 64'd0) ? PH_OUTCNT : PH_HASH;
                        end else begin
                            n_phase = (w_cnt_val == 64'd0) ? PH_LOCK : PH_AMT;
                        end
                    end
                end
            end
            PH_HASH: begin
                w_res_valid = 1'b1;
                w_res_pos   = r_fbc;
                n_fbc       = w_fbc_inc;
                if (w_fbc_inc >= LEN_HASH) begin
                    n_fbc   = 8'd0;
                    n_phase = PH_PIDX;
                end
            end
            PH_SIGLEN, PH_PKLEN: begin
                // Script length; an empty script skips to the next field.
                w_res_valid = 1'b1;
                n_srem      = r_in_byte;
                n_fbc       = 8'd0;
                if (r_phase == PH_SIGLEN) begin
                    n_phase = (r_in_byte == 8'd0) ? PH_SEQ : PH_SIG;
                end else if (r_in_byte == 8'd0) begin
                    n_ecount = w_last_entry ? '0 : w_cnt_next[COUNT_BITS-1:0];
                    n_phase  = w_last_entry ? PH_LOCK : PH_AMT;
                end else begin
                    n_phase = PH_PK;
                end
            end
            PH_SIG, PH_PK: begin
                // Script bytes, counted down by the remaining length.
                w_res_valid = 1'b1;
                w_res_pos   = r_fbc;
                n_fbc       = w_fbc_inc;
                n_srem      = r_srem - 8'd1;
                if (r_srem == 8'd1) begin
                    n_fbc = 8'd0;
                    if (r_phase == PH_SIG) begin
                        n_phase = PH_SEQ;
                    end else begin
                        n_ecount = w_last_entry ? '0 : w_cnt_next[COUNT_BITS-1:0];
                        n_phase  = w_last_entry ? PH_LOCK : PH_AMT;
                    end
                end
            end
            default: begin
                n_phase  = PH_VERSION;
                n_fbc    = 8'd0;
                n_acc    = 64'd0;
                n_vlen   = 4'd0;
                n_ecount = '0;
                n_etotal = '0;
                n_srem   = 8'd0;
            end
        endcase
    end

    // Input register control.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    // Input register payload.
    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_byte <= s_axis_tdata;
        end
    end

    // Parser state update, once per decoded byte.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_VERSION;
            r_fbc    <= 8'd0;
            r_acc    <= 64'd0;
            r_vlen   <= 4'd0;
            r_ecount <= '0;
            r_etotal <= '0;
            r_srem   <= 8'd0;
        end else if (w_advance) begin
            r_phase  <= n_phase;
            r_fbc    <= n_fbc;
            r_acc    <= n_acc;
            r_vlen   <= n_vlen;
            r_ecount <= n_ecount;
            r_etotal <= n_etotal;
            r_srem   <= n_srem;
        end
    end

    // Result register control.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_free) begin
            r_out_valid <= w_advance && w_res_valid;
        end
    end

    // Result register payload.
    always_ff @(posedge i_clk) begin
        if (w_advance && w_res_valid) begin
            r_out_kind  <= w_res_kind;
            r_out_value <= w_res_value;
            r_out_index <= w_res_index;
            r_out_pos   <= w_res_pos;
            r_out_end   <= w_res_end;
            r_out_err   <= w_res_err;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {r_out_pos, r_out_index, r_out_value};
    assign m_axis_tuser  = {r_out_err, r_out_kind};
    assign m_axis_tlast  = r_out_end;

    // A pending end-of-transaction or error result leaves the parser cleared.
    `CTSP_ASSERT_IMPL(a_end_clears, i_clk, i_rst_n,
        m_axis_tvalid && (m_axis_tlast || m_axis_tuser[4]),
        r_phase == PH_VERSION && r_acc == 64'd0 && r_fbc == 8'd0,
        "parser not cleared after end or error result")

    // Only the lock time ends a transaction.
    `CTSP_ASSERT_IMPL(a_end_kind, i_clk, i_rst_n,
        m_axis_tvalid && m_axis_tlast,
        m_axis_tuser[3:0] == PH_LOCK && !m_axis_tuser[4],
        "end of transaction on a field other than lock time")

    // Oversized counts are reported only on count results.
    `CTSP_ASSERT_IMPL(a_err_kind, i_clk, i_rst_n,
        m_axis_tvalid && m_axis_tuser[4],
        m_axis_tuser[3:0] == PH_INCNT || m_axis_tuser[3:0] == PH_OUTCNT,
        "count error on a non-count result")

    // Hash byte positions stay within the 32-byte hash.
    `CTSP_ASSERT_IMPL(a_hash_pos, i_clk, i_rst_n,
        m_axis_tvalid && m_axis_tuser[3:0] == PH_HASH,
        m_axis_tdata[103:96] < LEN_HASH,
        "hash byte position out of range")

endmodule

`default_nettype wire

// File: verif/testbench.sv
`timescale 1ns / 100ps
// ============================================================================
// Transaction stream parser regression
// Feeds serialized transactions, one byte per transfer, into the parser and
// checks every result against a cycle-free model of the field decoder. The
// stimulus is mostly well-formed transactions with random content. Bursts of
// stray bytes and oversized counts break the framing now and then. Both
// stream sides idle and stall at random.
// ============================================================================

module testbench;

    import ctsp_pkg::*;

    localparam int COUNT_BITS   = 32;
    localparam int RANDOM_BYTES = 800;
    localparam int DRAIN_CYCLES = 8;

    // One decoded field, as it leaves the parser.
    typedef struct {
        logic [3:0]  kind;
        logic [63:0] value;
        logic [31:0] entry;
        logic [7:0]  pos;
        logic        tx_end;
        logic        err;
    } t_field_result;

    // Tracks the decoder state and holds the fields it still owes.
    class parse_scoreboard;
        logic [3:0]    phase;
        logic [7:0]    field_bytes;
        logic [63:0]   accum;
        logic [3:0]    count_len;
        logic [31:0]   entry_num;
        logic [31:0]   entry_total;
        logic [7:0]    script_left;
        t_field_result pending_fields[$];
        int            n_mismatches;
        int            bytes_in;
        int            fields_checked;
        int            tx_closed;
        int            count_errors;
        logic [11:0]   kinds_seen;

        function new();
            clear_all();
            n_mismatches   = 0;
            bytes_in       = 0;
            fields_checked = 0;
            tx_closed      = 0;
            count_errors   = 0;
            kinds_seen     = '0;
        endfunction

        function void clear_all();
            phase       = PH_VERSION;
            field_bytes = '0;
            accum       = '0;
            count_len   = '0;
            entry_num   = '0;
            entry_total = '0;
            script_left = '0;
        endfunction

        function void push_field(logic [3:0] kind, logic [63:0] value, logic [31:0] entry,
                                 logic [7:0] pos, logic tx_end, logic err);
            t_field_result f;
            f.kind   = kind;
            f.value  = value;
            f.entry  = entry;
            f.pos    = pos;
            f.tx_end = tx_end;
            f.err    = err;
            pending_fields.push_back(f);
            kinds_seen[kind] = 1'b1;
            if (tx_end) tx_closed++;
            if (err) count_errors++;
        endfunction

        // Shifts one little-endian byte in; true once n bytes are in.
        function bit take_le_byte(logic [7:0] b, logic [7:0] n);
            accum       = accum | (64'(b) << (8 * field_bytes[2:0]));
            field_bytes = field_bytes + 8'd1;
            return field_bytes >= n;
        endfunction

        // Closes a fixed-width field and returns its value.
        function logic [63:0] close_field();
            logic [63:0] v;
            v           = accum;
            accum       = '0;
            field_bytes = '0;
            return v;
        endfunction

        function void next_entry(logic [3:0] more, logic [3:0] done);
            entry_num = entry_num + 32'd1;
            if (entry_num >= entry_total) begin
                entry_num = '0;
                phase     = done;
            end else begin
                phase = more;
            end
        endfunction

        // Compact-size count: one byte below 0xFD, or a prefix then 2, 4 or 8 count bytes.
        function void count_byte(logic [7:0] b, logic [3:0] kind);
            logic [63:0] v;
            if (count_len == 0) begin
                if (b < PFX_U16) begin
                    v = 64'(b);
                end else begin
                    count_len   = (b == PFX_U16) ? 4'd2 : (b == PFX_U32) ? 4'd4 : 4'd8;
                    field_bytes = '0;
                    accum       = '0;
                    return;
                end
            end else begin
                if (!take_le_byte(b, 8'(count_len))) return;
                v = accum;
            end
            count_len   = '0;
            field_bytes = '0;
            accum       = '0;
            if ((v >> COUNT_BITS) != 0) begin
                clear_all();
                push_field(kind, v, '0, '0, 1'b0, 1'b1);
                return;
            end
            entry_total = v[31:0];
            entry_num   = '0;
            if (kind == PH_INCNT) phase = (v == 0) ? PH_OUTCNT : PH_HASH;
            else phase = (v == 0) ? PH_LOCK : PH_AMT;
            push_field(kind, v, '0, '0, 1'b0, 1'b0);
        endfunction

        // Notes one accepted byte and queues the field it completes, if any.
        function void note_byte(logic [7:0] b);
            logic [7:0] pos;
            bytes_in++;
            case (phase)
                PH_VERSION: begin
                    if (take_le_byte(b, LEN_WORD)) begin
                        push_field(PH_VERSION, close_field(), '0, '0, 1'b0, 1'b0);
                        phase = PH_INCNT;
                    end
                end
                PH_INCNT, PH_OUTCNT: count_byte(b, phase);
                PH_HASH: begin
                    pos         = field_bytes;
                    field_bytes = field_bytes + 8'd1;
                    if (field_bytes >= LEN_HASH) begin
                        field_bytes = '0;
                        phase       = PH_PIDX;
                    end
                    push_field(PH_HASH, 64'(b), entry_num, pos, 1'b0, 1'b0);
                end
                PH_PIDX: begin
                    if (take_le_byte(b, LEN_WORD)) begin
                        push_field(PH_PIDX, close_field(), entry_num, '0, 1'b0, 1'b0);
                        phase = PH_SIGLEN;
                    end
                end
                PH_SIGLEN: begin
                    script_left = b;
                    field_bytes = '0;
                    phase       = (b == 0) ? PH_SEQ : PH_SIG;
                    push_field(PH_SIGLEN, 64'(b), entry_num, '0, 1'b0, 1'b0);
                end
                PH_SIG: begin
                    pos         = field_bytes;
                    field_bytes = field_bytes + 8'd1;
                    script_left = script_left - 8'd1;
                    if (script_left == 0) begin
                        field_bytes = '0;
                        phase       = PH_SEQ;
                    end
                    push_field(PH_SIG, 64'(b), entry_num, pos, 1'b0, 1'b0);
                end
                PH_SEQ: begin
                    if (take_le_byte(b, LEN_WORD)) begin
                        push_field(PH_SEQ, close_field(), entry_num, '0, 1'b0, 1'b0);
                        next_entry(PH_HASH, PH_OUTCNT);
                    end
                end
                PH_AMT: begin
                    if (take_le_byte(b, LEN_AMT)) begin
                        push_field(PH_AMT, close_field(), entry_num, '0, 1'b0, 1'b0);
                        phase = PH_PKLEN;
                    end
                end
                PH_PKLEN: begin
                    push_field(PH_PKLEN, 64'(b), entry_num, '0, 1'b0, 1'b0);
                    script_left = b;
                    field_bytes = '0;
                    if (b == 0) next_entry(PH_AMT, PH_LOCK);
                    else phase = PH_PK;
                end
                PH_PK: begin
                    push_field(PH_PK, 64'(b), entry_num, field_bytes, 1'b0, 1'b0);
                    field_bytes = field_bytes + 8'd1;
                    script_left = script_left - 8'd1;
                    if (script_left == 0) begin
                        field_bytes = '0;
                        next_entry(PH_AMT, PH_LOCK);
                    end
                end
                PH_LOCK: begin
                    if (take_le_byte(b, LEN_WORD)) begin
                        push_field(PH_LOCK, accum, '0, '0, 1'b1, 1'b0);
                        clear_all();
                    end
                end
                default: clear_all();
            endcase
        endfunction

        task report_mismatch(string msg);
            n_mismatches++;
            if (n_mismatches <= 30) $display("MISMATCH: %s", msg);
        endtask

        // Compares one accepted result with the oldest field still owed.
        task check_field(t_field_result got);
            t_field_result want;
            if (pending_fields.size() == 0) begin
                report_mismatch($sformatf("unexpected result kind %0d value 0x%0h",
                                          got.kind, got.value));
                return;
            end
            want = pending_fields.pop_front();
            fields_checked++;
            if (got.kind !== want.kind)
                report_mismatch($sformatf("field %0d: kind %0d, want %0d",
                                          fields_checked, got.kind, want.kind));
            if (got.value !== want.value)
                report_mismatch($sformatf("field %0d: value 0x%0h, want 0x%0h",
                                          fields_checked, got.value, want.value));
            if (got.entry !== want.entry)
                report_mismatch($sformatf("field %0d: entry %0d, want %0d",
                                          fields_checked, got.entry, want.entry));
            if (got.pos !== want.pos)
                report_mismatch($sformatf("field %0d: position %0d, want %0d",
                                          fields_checked, got.pos, want.pos));
            if (got.tx_end !== want.tx_end)
                report_mismatch($sformatf("field %0d: end flag %b, want %b",
                                          fields_checked, got.tx_end, want.tx_end));
            if (got.err !== want.err)
                report_mismatch($sformatf("field %0d: count error %b, want %b",
                                          fields_checked, got.err, want.err));
        endtask
    endclass

    logic           i_clk         = 1'b0;
    logic           i_rst_n       = 1'b0;
    logic           s_axis_tvalid = 1'b0;
    logic [7:0]     s_axis_tdata  = '0;
    logic           m_axis_tready = 1'b0;
    logic           s_axis_tready;
    logic           m_axis_tvalid;
    logic [103:0]   m_axis_tdata;
    logic [4:0]     m_axis_tuser;
    logic           m_axis_tlast;

    parse_scoreboard sb;
    logic [7:0]      byte_plan_q[$];
    int              noise_left = 0;
    logic [8:0]      rx_cycle   = '0;

    // Directed opening: an all-ones version with empty input and output lists,
    // then a transaction whose input count overflows 32 bits.
    logic [7:0] opening_bytes[$] = '{
        8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00, PFX_U64,
        8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF
    };

    coin_transaction_stream_parser_core #(
        .COUNT_BITS(COUNT_BITS)
    ) i_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),   // data_byte [7:0]
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),   // field_value, entry_index, byte_position
        .m_axis_tuser (m_axis_tuser),   // field_kind [3:0], count_error [4]
        .m_axis_tlast (m_axis_tlast)    // tx_end
    );

    always #1 i_clk = ~i_clk;

    // Content bytes lean toward the all-zeros and all-ones extremes.
    function automatic logic [7:0] content_byte();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) return 8'h00;
        if (r == 1) return 8'hFF;
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic void plan_le(logic [63:0] v, int nbytes);
        for (int k = 0; k < nbytes; k++) byte_plan_q.push_back(v[8*k +: 8]);
    endfunction

    function automatic void plan_bytes(int nbytes);
        for (int k = 0; k < nbytes; k++) byte_plan_q.push_back(content_byte());
    endfunction

    // A compact-size count in one of its four encodings, or an oversized one.
    function automatic void plan_count(int max_entries);
        int          r;
        int          enc;
        logic [63:0] v;
        r = $urandom_range(0, 99);
        if (r < 7) begin
            v = (r == 0) ? '1 : {32'($urandom) | (32'd1 << $urandom_range(0, 31)),
                                 32'($urandom)};
            byte_plan_q.push_back(PFX_U64);
            plan_le(v, 8);
            return;
        end
        v   = 64'($urandom_range(0, max_entries));
        enc = $urandom_range(0, 9);
        if (enc <= 5) begin
            byte_plan_q.push_back(v[7:0]);
        end else if (enc <= 7) begin
            byte_plan_q.push_back(PFX_U16);
            plan_le(v, 2);
        end else if (enc == 8) begin
            byte_plan_q.push_back(PFX_U32);
            plan_le(v, 4);
        end else begin
            byte_plan_q.push_back(PFX_U64);
            plan_le(v, 8);
        end
    endfunction

    // Mostly short scripts, some empty, now and then the longest one.
    function automatic logic [7:0] script_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 20) return 8'd0;
        if (r < 85) return 8'($urandom_range(1, 6));
        if (r < 97) return 8'($urandom_range(7, 40));
        return 8'd255;
    endfunction

    // Plans the rest of the field the parser is in. Stray bytes never land
    // on a count, so a runaway entry count cannot occur.
    function automatic void plan_field();
        if (sb.phase == PH_INCNT || sb.phase == PH_OUTCNT) begin
            plan_count((sb.phase == PH_INCNT) ? 2 : 3);
            return;
        end
        if (noise_left == 0 && $urandom_range(0, 39) == 0)
            noise_left = $urandom_range(1, 10);
        if (noise_left > 0) begin
            byte_plan_q.push_back(8'($urandom_range(0, 255)));
            noise_left--;
            return;
        end
        case (sb.phase)
            PH_VERSION, PH_PIDX, PH_SEQ, PH_LOCK: plan_bytes(int'(LEN_WORD) - sb.field_bytes);
            PH_AMT:              plan_bytes(int'(LEN_AMT) - sb.field_bytes);
            PH_HASH:             plan_bytes(int'(LEN_HASH) - sb.field_bytes);
            PH_SIGLEN, PH_PKLEN: byte_plan_q.push_back(script_len());
            PH_SIG, PH_PK:       plan_bytes(int'(sb.script_left));
            default:             byte_plan_q.push_back(8'($urandom_range(0, 255)));
        endcase
    endfunction

    // Offers one byte and holds it until the parser takes the transfer.
    task automatic send_byte(logic [7:0] b);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        do @(posedge i_clk); while (!s_axis_tready);
        sb.note_byte(b);
    endtask

    task automatic idle_for(int n);
        if (n == 0) return;
        s_axis_tvalid <= 1'b0;
        repeat (n) @(posedge i_clk);
    endtask

    function automatic bit stimulus_done(int sent);
        return sent >= RANDOM_BYTES && sb.phase == PH_VERSION && sb.field_bytes == 0;
    endfunction

    // Receiver pattern: free running, coin-flip, one in four, rare stalls.
    always @(posedge i_clk) begin
        rx_cycle <= rx_cycle + 9'd1;
        case (rx_cycle[8:7])
            2'd0:    m_axis_tready <= 1'b1;
            2'd1:    m_axis_tready <= 1'($urandom_range(0, 1));
            2'd2:    m_axis_tready <= (rx_cycle[1:0] == 2'd0);
            default: m_axis_tready <= ($urandom_range(0, 4) != 0);
        endcase
    end

    // Result monitor.
    always @(posedge i_clk) begin
        t_field_result got;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got.value  = m_axis_tdata[63:0];
            got.entry  = m_axis_tdata[95:64];
            got.pos    = m_axis_tdata[103:96];
            got.kind   = m_axis_tuser[3:0];
            got.err    = m_axis_tuser[4];
            got.tx_end = m_axis_tlast;
            sb.check_field(got);
        end
    end

    initial begin : stimulus
        int random_sent;
        int burst;
        sb = new();
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (opening_bytes[k]) send_byte(opening_bytes[k]);

        // Random transactions sent in bursts with gaps between them.
        random_sent = 0;
        while (!stimulus_done(random_sent)) begin
            burst = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 200)
                                                : $urandom_range(1, 16);
            while (burst > 0 && !stimulus_done(random_sent)) begin
                if (byte_plan_q.size() == 0) plan_field();
                send_byte(byte_plan_q.pop_front());
                random_sent++;
                burst--;
            end
            idle_for(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5));
        end
        s_axis_tvalid <= 1'b0;

        // Drain the fields still owed, then let the pipeline settle.
        while (sb.pending_fields.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Fed %0d bytes and checked %0d fields: %0d transactions closed, %0d %s",
                 sb.bytes_in, sb.fields_checked, sb.tx_closed, sb.count_errors,
                 "oversized counts.");
        $display("Field kinds seen: %0d of 12, mismatches: %0d.",
                 $countones(sb.kinds_seen), sb.n_mismatches);
        if (sb.n_mismatches == 0) begin
            $display("coin_transaction_stream_parser_core regression: pass");
        end else begin
            $display("coin_transaction_stream_parser_core regression: fail");
        end
        $finish;
    end

    // Watchdog for a hung stream.
    initial begin
        #400000;
        $display("Timed out with %0d fields still owed.", sb.pending_fields.size());
        $display("coin_transaction_stream_parser_core regression: fail");
        $finish;
    end

endmodule
